>>> rtl/byte_tape_machine_stepper_top_macros.svh
// ----------------------------------------------------------------------------
// Byte tape machine stepper - assertion macros
// Short forms for the concurrent checks used by the RTL. The including module
// must provide clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef BYTE_TAPE_MACHINE_STEPPER_TOP_MACROS_SVH
`define BYTE_TAPE_MACHINE_STEPPER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BTMS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BTMS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/btms_pkg.sv
// ----------------------------------------------------------------------------
// btms_pkg
// Shared types, codes and default sizes of the byte tape machine stepper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package btms_pkg;

  // Default sizes of the stores.
  localparam int TAPE_CELLS_DEF    = 32768;
  localparam int PROGRAM_DEPTH_DEF = 4096;
  localparam int NEST_DEPTH_DEF    = 64;
  localparam int INPUT_DEPTH_DEF   = 256;

  // Instruction bytes.
  localparam logic [7:0] OP_INC   = 8'h2B;  // '+'
  localparam logic [7:0] OP_DEC   = 8'h2D;  // '-'
  localparam logic [7:0] OP_RIGHT = 8'h3E;  // '>'
  localparam logic [7:0] OP_LEFT  = 8'h3C;  // '<'
  localparam logic [7:0] OP_IN    = 8'h2C;  // ','
  localparam logic [7:0] OP_OUT   = 8'h2E;  // '.'
  localparam logic [7:0] OP_OPEN  = 8'h5B;  // '['
  localparam logic [7:0] OP_CLOSE = 8'h5D;  // ']'

  localparam logic [7:0]  CELL_MAX = 8'hFF;
  localparam logic [15:0] WCNT_MAX = 16'hFFFF;

  // Request function codes.
  typedef enum logic [1:0] {
    FN_PROG  = 2'd0,
    FN_INPUT = 2'd1,
    FN_STEP  = 2'd2,
    FN_CLEAR = 2'd3
  } func_t;

  // Warning codes reported with each result.
  typedef enum logic [2:0] {
    WARN_NONE       = 3'd0,
    WARN_OVERFLOW   = 3'd1,
    WARN_UNDERFLOW  = 3'd2,
    WARN_RIGHT_EDGE = 3'd3,
    WARN_LEFT_EDGE  = 3'd4,
    WARN_NO_CLOSE   = 3'd5,
    WARN_EMPTY_LOOP = 3'd6,
    WARN_FULL       = 3'd7
  } warn_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_LINK
  } state_t;

  // Control from the sequencer to the tape memory.
  typedef struct packed {
    logic wr_en;
    logic sweep_start;
  } tape_ctl_t;

endpackage

`default_nettype wire

>>> rtl/byte_tape_machine_stepper_top.sv
// ----------------------------------------------------------------------------
// byte_tape_machine_stepper_top
// Eight-instruction byte tape machine that loads a program and input bytes
// and runs one instruction per step request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, in_func, in_data_byte) carries one
//   request: append a program byte, append an input byte, execute one
//   instruction, or clear all state. Every request yields exactly one result
//   on the output channel (out_valid/out_ready) with the emitted byte flag
//   and value, a warning code, the halted flag and the saturating warning
//   count.
//   Timing: a request is accepted in the idle cycle, its memories are read
//   on that edge and the result is registered from the execute state.
//   Appending a ']' that closes a '[' also passes through the link state,
//   since both ends are written through the single write port of the jump
//   table memory.
//   Reset and clear: the tape is zeroed by a sweep over all TAPE_CELLS cells
//   (32768 by default), one cell per cycle through the tape write port; in_ready
//   stays low during it. A clear request delivers its result, then sweeps.
//   Stall: a finished result waits in the output register. The following
//   request is accepted and read, but it commits only once that register is
//   free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "byte_tape_machine_stepper_top_macros.svh"

module byte_tape_machine_stepper_top #(
  parameter int TAPE_CELLS    = btms_pkg::TAPE_CELLS_DEF,
  parameter int PROGRAM_DEPTH = btms_pkg::PROGRAM_DEPTH_DEF,
  parameter int NEST_DEPTH    = btms_pkg::NEST_DEPTH_DEF,
  parameter int INPUT_DEPTH   = btms_pkg::INPUT_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_func,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_out_valid,
  output logic [7:0]       out_out_byte,
  output logic [2:0]       out_warning_code,
  output logic             out_halted,
  output logic [15:0]      out_warnings_so_far
);

  // Address and counter widths.
  localparam int PAW = $clog2(PROGRAM_DEPTH);
  localparam int PCW = $clog2(PROGRAM_DEPTH + 1);
  localparam int SAW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
  localparam int SPW = $clog2(NEST_DEPTH + 1);
  localparam int IAW = (INPUT_DEPTH > 1) ? $clog2(INPUT_DEPTH) : 1;
  localparam int IPW = $clog2(INPUT_DEPTH + 1);
  localparam int TPW = $clog2(TAPE_CELLS);

  // Memories.
  logic [7:0]   prog_mem  [PROGRAM_DEPTH];
  logic [PAW:0] jump_mem  [PROGRAM_DEPTH];
  logic [PAW-1:0] stack_mem [NEST_DEPTH];
  logic [7:0]   inbuf_mem [INPUT_DEPTH];

  logic [7:0]     prog_rd_r;
  logic [PAW:0]   jump_rd_r;
  logic [PAW-1:0] stack_rd_r;
  logic [7:0]     inbuf_rd_r;

  // Sequencer and architectural registers.
  btms_pkg::state_t state_r, state_nxt;
  btms_pkg::func_t  func_r;
  logic [7:0]       byte_r;
  logic [PCW-1:0]   pc_r, pc_nxt;
  logic [PCW-1:0]   len_r, len_nxt;
  logic [SPW-1:0]   sp_r, sp_nxt;
  logic [TPW-1:0]   tp_r, tp_nxt;
  logic [IPW-1:0]   wr_r, wr_nxt;
  logic [IPW-1:0]   rd_r, rd_nxt;
  logic [15:0]      wcnt_r, wcnt_nxt;
  logic [PAW-1:0]   link_open_r, link_pos_r;

  // Output register.
  logic        out_valid_r;
  logic        res_ovalid_r;
  logic [7:0]  res_obyte_r;
  logic [2:0]  res_warn_r;
  logic        res_halted_r;
  logic [15:0] res_wcnt_r;

  // Step datapath signals.
  logic             can_load;
  logic             commit;
  logic             link_req;
  logic             prog_wr, jump_wr, stack_wr, inbuf_wr;
  logic [PAW:0]     jump_wd_exec;
  logic             jump_we;
  logic [PAW-1:0]   jump_wa;
  logic [PAW:0]     jump_wd;
  logic [SPW-1:0]   sp_dec;
  btms_pkg::warn_t  warn;
  logic             warn_hit;
  logic             res_ovalid;
  logic [7:0]       res_obyte;
  logic             sweep_req;
  logic             tape_wr;
  logic [7:0]       tape_wd;
  logic [7:0]       tape_rd;
  logic             tape_busy;
  logic             jmp_matched;
  logic [PCW-1:0]   jmp_tgt;
  logic [PCW-1:0]   pc_inc;
  btms_pkg::tape_ctl_t tape_ctl;

  assign can_load = !out_valid_r || out_ready;
  assign commit   = (state_r == btms_pkg::ST_EXEC) && can_load;
  assign sp_dec   = sp_r - SPW'(1);
  assign jmp_matched = jump_rd_r[PAW];
  assign jmp_tgt  = PCW'(jump_rd_r[PAW-1:0]);
  assign pc_inc   = pc_r + PCW'(1);

  // Tape memory with its clearing sweep.
  assign tape_ctl.wr_en       = commit && tape_wr;
  assign tape_ctl.sweep_start = commit && sweep_req;

  btms_tape #(
    .TAPE_CELLS (TAPE_CELLS)
  ) u_tape (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (tape_ctl),
    .addr    (tp_r),
    .wr_data (tape_wd),
    .rd_data (tape_rd),
    .busy    (tape_busy)
  );

  // Program store: written at the program length, read at the counter.
  always_ff @(posedge clk) begin
    if (commit && prog_wr) begin
      prog_mem[len_r[PAW-1:0]] <= byte_r;
    end
    prog_rd_r <= prog_mem[pc_r[PAW-1:0]];
  end

  // Jump table: the second write of a matched pair lands in the link cycle.
  always_comb begin
    if (state_r == btms_pkg::ST_LINK) begin
      jump_we = 1'b1;
      jump_wa = link_open_r;
      jump_wd = {1'b1, link_pos_r};
    end else begin
      jump_we = commit && jump_wr;
      jump_wa = len_r[PAW-1:0];
      jump_wd = jump_wd_exec;
    end
  end

  always_ff @(posedge clk) begin
    if (jump_we) begin
      jump_mem[jump_wa] <= jump_wd;
    end
    jump_rd_r <= jump_mem[pc_r[PAW-1:0]];
  end

  // Bracket stack: the top entry is read ahead of every request.
  always_ff @(posedge clk) begin
    if (commit && stack_wr) begin
      stack_mem[sp_r[SAW-1:0]] <= len_r[PAW-1:0];
    end
    stack_rd_r <= stack_mem[sp_dec[SAW-1:0]];
  end

  // Input buffer.
  always_ff @(posedge clk) begin
    if (commit && inbuf_wr) begin
      inbuf_mem[wr_r[IAW-1:0]] <= byte_r;
    end
    inbuf_rd_r <= inbuf_mem[rd_r[IAW-1:0]];
  end

  // Step datapath: effects of the request held in func_r and byte_r.
  always_comb begin
    pc_nxt       = pc_r;
    len_nxt      = len_r;
    sp_nxt       = sp_r;
    tp_nxt       = tp_r;
    wr_nxt       = wr_r;
    rd_nxt       = rd_r;
    prog_wr      = 1'b0;
    jump_wr      = 1'b0;
    jump_wd_exec = '0;
    stack_wr     = 1'b0;
    inbuf_wr     = 1'b0;
    link_req     = 1'b0;
    warn         = btms_pkg::WARN_NONE;
    warn_hit     = 1'b0;
    res_ovalid   = 1'b0;
    res_obyte    = 8'h00;
    sweep_req    = 1'b0;
    tape_wr      = 1'b0;
    tape_wd      = tape_rd;

    unique case (func_r)
      btms_pkg::FN_PROG: begin
        if (len_r >= PCW'(PROGRAM_DEPTH)) begin
          warn     = btms_pkg::WARN_FULL;
          warn_hit = 1'b1;
        end else if ((byte_r == btms_pkg::OP_OPEN) && (sp_r >= SPW'(NEST_DEPTH))) begin
          warn     = btms_pkg::WARN_FULL;
          warn_hit = 1'b1;
        end else begin
          prog_wr = 1'b1;
          jump_wr = 1'b1;
          len_nxt = len_r + PCW'(1);
          if (byte_r == btms_pkg::OP_OPEN) begin
            stack_wr = 1'b1;
            sp_nxt   = sp_r + SPW'(1);
          end else if ((byte_r == btms_pkg::OP_CLOSE) && (sp_r != '0)) begin
            sp_nxt       = sp_dec;
            jump_wd_exec = {1'b1, stack_rd_r};
            link_req     = 1'b1;
          end
        end
      end

      btms_pkg::FN_INPUT: begin
        if (wr_r >= IPW'(INPUT_DEPTH)) begin
          warn     = btms_pkg::WARN_FULL;
          warn_hit = 1'b1;
        end else begin
          inbuf_wr = 1'b1;
          wr_nxt   = wr_r + IPW'(1);
        end
      end

      btms_pkg::FN_STEP: begin
        if (pc_r < len_r) begin
          pc_nxt = pc_inc;
          unique case (prog_rd_r)
            btms_pkg::OP_INC: begin
              if (tape_rd == btms_pkg::CELL_MAX) begin
                warn     = btms_pkg::WARN_OVERFLOW;
                warn_hit = 1'b1;
              end
              tape_wr = 1'b1;
              tape_wd = tape_rd + 8'd1;
            end
            btms_pkg::OP_DEC: begin
              if (tape_rd == 8'h00) begin
                warn     = btms_pkg::WARN_UNDERFLOW;
                warn_hit = 1'b1;
              end
              tape_wr = 1'b1;
              tape_wd = tape_rd - 8'd1;
            end
            btms_pkg::OP_RIGHT: begin
              if (tp_r == TPW'(TAPE_CELLS - 1)) begin
                warn     = btms_pkg::WARN_RIGHT_EDGE;
                warn_hit = 1'b1;
              end else begin
                tp_nxt = tp_r + TPW'(1);
              end
            end
            btms_pkg::OP_LEFT: begin
              if (tp_r == '0) begin
                warn     = btms_pkg::WARN_LEFT_EDGE;
                warn_hit = 1'b1;
              end else begin
                tp_nxt = tp_r - TPW'(1);
              end
            end
            btms_pkg::OP_IN: begin
              tape_wr = 1'b1;
              if (rd_r < wr_r) begin
                tape_wd = inbuf_rd_r;
                rd_nxt  = rd_r + IPW'(1);
              end else begin
                tape_wd = 8'h00;
              end
            end
            btms_pkg::OP_OUT: begin
              res_ovalid = 1'b1;
              res_obyte  = tape_rd;
            end
            btms_pkg::OP_OPEN: begin
              if (!jmp_matched) begin
                warn     = btms_pkg::WARN_NO_CLOSE;
                warn_hit = 1'b1;
              end else if (jmp_tgt == pc_inc) begin
                warn     = btms_pkg::WARN_EMPTY_LOOP;
                warn_hit = 1'b1;
                pc_nxt   = jmp_tgt + PCW'(1);
              end else if (tape_rd == 8'h00) begin
                pc_nxt = jmp_tgt + PCW'(1);
              end
            end
            btms_pkg::OP_CLOSE: begin
              if (jmp_matched && (tape_rd != 8'h00)) begin
                pc_nxt = jmp_tgt + PCW'(1);
              end
            end
            default: begin
            end
          endcase
        end
      end

      btms_pkg::FN_CLEAR: begin
        pc_nxt    = '0;
        len_nxt   = '0;
        sp_nxt    = '0;
        tp_nxt    = '0;
        wr_nxt    = '0;
        rd_nxt    = '0;
        sweep_req = 1'b1;
      end
    endcase
  end

  // Saturating warning count; a clear restarts it.
  always_comb begin
    if (func_r == btms_pkg::FN_CLEAR) begin
      wcnt_nxt = '0;
    end else if (warn_hit && (wcnt_r != btms_pkg::WCNT_MAX)) begin
      wcnt_nxt = wcnt_r + 16'd1;
    end else begin
      wcnt_nxt = wcnt_r;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      btms_pkg::ST_CLEAR: begin
        if (!tape_busy) begin
          state_nxt = btms_pkg::ST_IDLE;
        end
      end
      btms_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = btms_pkg::ST_EXEC;
        end
      end
      btms_pkg::ST_EXEC: begin
        if (can_load) begin
          if (sweep_req) begin
            state_nxt = btms_pkg::ST_CLEAR;
          end else if (link_req) begin
            state_nxt = btms_pkg::ST_LINK;
          end else begin
            state_nxt = btms_pkg::ST_IDLE;
          end
        end
      end
      btms_pkg::ST_LINK: begin
        state_nxt = btms_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = btms_pkg::ST_CLEAR;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready = (state_r == btms_pkg::ST_IDLE);
  end

  // State register, and architectural registers updated when a request commits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= btms_pkg::ST_CLEAR;
      pc_r    <= '0;
      len_r   <= '0;
      sp_r    <= '0;
      tp_r    <= '0;
      wr_r    <= '0;
      rd_r    <= '0;
      wcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        pc_r   <= pc_nxt;
        len_r  <= len_nxt;
        sp_r   <= sp_nxt;
        tp_r   <= tp_nxt;
        wr_r   <= wr_nxt;
        rd_r   <= rd_nxt;
        wcnt_r <= wcnt_nxt;
      end
    end
  end

  // Request capture and pending link of a matched bracket pair.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      func_r <= btms_pkg::func_t'(in_func);
      byte_r <= in_data_byte;
    end
    if (commit && link_req) begin
      link_open_r <= stack_rd_r;
      link_pos_r  <= len_r[PAW-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      res_ovalid_r <= res_ovalid;
      res_obyte_r  <= res_obyte;
      res_warn_r   <= warn;
      res_halted_r <= (pc_nxt >= len_nxt);
      res_wcnt_r   <= wcnt_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_out_valid       = res_ovalid_r;
  assign out_out_byte        = res_obyte_r;
  assign out_warning_code    = res_warn_r;
  assign out_halted          = res_halted_r;
  assign out_warnings_so_far = res_wcnt_r;

  // Checks.
  `BTMS_ASSERT_NOW(a_sweep_blocks_in, tape_busy, !in_ready, "request taken during tape sweep")
  `BTMS_ASSERT_NOW(a_len_bound, 1'b1, len_r <= PCW'(PROGRAM_DEPTH), "program length overrun")
  `BTMS_ASSERT_NOW(a_sp_bound, 1'b1, sp_r <= SPW'(NEST_DEPTH), "bracket stack overrun")
  `BTMS_ASSERT_NOW(a_rd_behind_wr, 1'b1, rd_r <= wr_r, "input read pointer passed write pointer")
  `BTMS_ASSERT_NEXT(a_link_follows, commit && link_req, state_r == btms_pkg::ST_LINK, "missing link cycle")

endmodule

`default_nettype wire

>>> rtl/btms_tape.sv
// ----------------------------------------------------------------------------
// btms_tape
// Tape memory with one registered read port, one write port and a clearing
// sweep that zeroes every cell after reset or on request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module btms_tape #(
  parameter int TAPE_CELLS = btms_pkg::TAPE_CELLS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire btms_pkg::tape_ctl_t           ctl,
  input  wire logic [$clog2(TAPE_CELLS)-1:0] addr,
  input  wire logic [7:0]                    wr_data,
  output logic      [7:0]                    rd_data,
  output logic                               busy
);

  localparam int TAW = $clog2(TAPE_CELLS);
  localparam logic [TAW-1:0] LAST_CELL = TAW'(TAPE_CELLS - 1);

  logic [7:0]     mem [TAPE_CELLS];
  logic [7:0]     rd_data_r;
  logic           busy_r;
  logic [TAW-1:0] sweep_cnt_r;
  logic           we;
  logic [TAW-1:0] wa;
  logic [7:0]     wd;

  // The sweep owns the write port while it runs.
  always_comb begin
    if (busy_r) begin
      we = 1'b1;
      wa = sweep_cnt_r;
      wd = 8'h00;
    end else begin
      we = ctl.wr_en;
      wa = addr;
      wd = wr_data;
    end
  end

  // Memory array: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= mem[addr];
  end

  // Clearing sweep, one cell per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      sweep_cnt_r <= '0;
    end else if (ctl.sweep_start) begin
      busy_r      <= 1'b1;
      sweep_cnt_r <= '0;
    end else if (busy_r) begin
      if (sweep_cnt_r == LAST_CELL) begin
        busy_r <= 1'b0;
      end else begin
        sweep_cnt_r <= sweep_cnt_r + TAW'(1);
      end
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = busy_r;

endmodule

`default_nettype wire
